@@ hw/rtl/srdr_pkg.sv @@
// ----------------------------------------------------------------------------
// srdr_pkg: shared types and constants of the stereo rotating delay reverb
// Sample and coefficient formats, stream packing offsets, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package srdr_pkg;

    localparam int SAMPLE_W = 24;              // Q1.23 samples
    localparam int COEF_W   = 18;              // Q1.17 signed coefficients
    localparam int CFRAC    = COEF_W - 1;      // coefficient fraction bits
    localparam int UCOEF_W  = CFRAC;           // unsigned Q0.17 gains
    localparam int GUARD    = 8;               // extra fraction bits in filters
    localparam int FILT_W   = SAMPLE_W + GUARD + 1;
    localparam int IDX_W    = 5;
    localparam int LEN_FW   = 14;              // width of the delay_length field
    localparam int CFG_W    = 6;

    // input tdata layout, lowest bit first
    localparam int OFS_IDX  = 0;
    localparam int OFS_LEN  = OFS_IDX + IDX_W;
    localparam int OFS_GAIN = OFS_LEN + LEN_FW;
    localparam int OFS_RE   = OFS_GAIN + UCOEF_W;
    localparam int OFS_IM   = OFS_RE + COEF_W;
    localparam int OFS_FC   = OFS_IM + COEF_W;
    localparam int OFS_SL   = OFS_FC + UCOEF_W;
    localparam int OFS_SR   = OFS_SL + SAMPLE_W;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 2 * SAMPLE_W;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/stereo_rotating_delay_reverb.sv @@
// ----------------------------------------------------------------------------
// stereo_rotating_delay_reverb: parallel feedback comb reverb, stereo
// Per-line lowpass, complex rotation feedback and saturated mix to output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser = action, tdata = line parameters and the
//   stereo sample. A load item (tuser high) writes one line's settings
//   and returns nothing. A sample item runs every active line and
//   returns one item on m_axis with the saturated left/right outputs.
//   cfg_wr_en/cfg_wr_data set the number of active lines at any idle time.
//   Lines stream through a seven-stage pipeline, one line issued per cycle;
//   the single read port of the delay memory sets this one-line-per-cycle
//   rate. The next item is accepted in the cycle after the result is loaded
//   into the output register.
//   After reset the delay memory is swept clear, one entry per cycle, over
//   all NUM_LINES * 2^ceil(log2(MAX_DELAY)) entries (262144 at the defaults),
//   during which s_axis_tready stays low. The result sits in an output
//   register; a stalled receiver holds it, and a following sample item
//   waits at its end until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_rotating_delay_reverb #(
    parameter int NUM_LINES = 32,
    parameter int MAX_DELAY = 8192
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [srdr_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // line_index, delay_length, gain_in, feedback_re, feedback_im,
    // filter_coeff, sample_left, sample_right, zero pad
    input  wire logic [srdr_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tuser,   // action
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [srdr_pkg::M_DATA_W-1:0]      m_axis_tdata    // out_left, out_right
);

    localparam int SW    = srdr_pkg::SAMPLE_W;
    localparam int CF    = srdr_pkg::CFRAC;
    localparam int UW    = srdr_pkg::UCOEF_W;
    localparam int CW_   = srdr_pkg::COEF_W;
    localparam int FW    = srdr_pkg::FILT_W;
    localparam int G     = srdr_pkg::GUARD;
    localparam int LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int PW    = $clog2(MAX_DELAY);
    localparam int LENW  = $clog2(MAX_DELAY + 1);
    localparam int AW    = LW + PW;
    localparam int DEPTH = NUM_LINES * (2 ** PW);
    localparam int NW    = $clog2(NUM_LINES + 1);
    localparam int ACCW  = FW + NW;
    localparam int DW    = FW + 1;             // filter difference
    localparam int PRW   = DW + CW_;           // filter product
    localparam int RW    = CW_ + FW;           // rotation product
    localparam int GW    = CW_ + SW + G;       // gained input, guard applied
    localparam int TW    = RW + 2;             // write-back sum
    localparam int NCW   = (NUM_LINES > 63) ? NW : srdr_pkg::CFG_W + 1;

    // ------------------------------------------------------------------
    // input field decode
    // ------------------------------------------------------------------
    logic [srdr_pkg::IDX_W-1:0]  in_idx;
    logic [srdr_pkg::LEN_FW-1:0] in_len;
    logic [UW-1:0]               in_gain, in_fc;
    logic [CW_-1:0]              in_re, in_im;
    logic [SW-1:0]               in_sl, in_sr;
    logic [LENW-1:0]             len_clamped;

    assign in_idx  = s_axis_tdata[srdr_pkg::OFS_IDX +: srdr_pkg::IDX_W];
    assign in_len  = s_axis_tdata[srdr_pkg::OFS_LEN +: srdr_pkg::LEN_FW];
    assign in_gain = s_axis_tdata[srdr_pkg::OFS_GAIN +: UW];
    assign in_re   = s_axis_tdata[srdr_pkg::OFS_RE +: CW_];
    assign in_im   = s_axis_tdata[srdr_pkg::OFS_IM +: CW_];
    assign in_fc   = s_axis_tdata[srdr_pkg::OFS_FC +: UW];
    assign in_sl   = s_axis_tdata[srdr_pkg::OFS_SL +: SW];
    assign in_sr   = s_axis_tdata[srdr_pkg::OFS_SR +: SW];

    always_comb begin
        if (in_len == '0) begin
            len_clamped = LENW'(1);
        end else if (32'(in_len) > MAX_DELAY) begin
            len_clamped = LENW'(MAX_DELAY);
        end else begin
            len_clamped = LENW'(in_len);
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    srdr_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic [srdr_pkg::CFG_W-1:0] active_reg;
    logic [NW-1:0]    iss_cnt_reg;
    logic [NW-1:0]    n_lines;
    logic [7:1]       vld_reg;
    logic             in_acc, sample_acc, load_acc, clr_last, issue, run_done, out_load;
    logic             m_valid_reg;

    assign n_lines = (NCW'(active_reg) > NCW'(NUM_LINES)) ? NW'(NUM_LINES)
                                                          : NW'(active_reg);
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign sample_acc = in_acc && (s_axis_tuser == srdr_pkg::ACT_SAMPLE);
    assign load_acc   = in_acc && (s_axis_tuser == srdr_pkg::ACT_LOAD)
                        && (32'(in_idx) < NUM_LINES);
    assign clr_last   = (clr_cnt_reg == AW'(DEPTH - 1));
    assign issue      = (state_reg == srdr_pkg::ST_RUN) && (iss_cnt_reg != n_lines);
    assign run_done   = (state_reg == srdr_pkg::ST_RUN) && !issue && (vld_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srdr_pkg::ST_CLEAR: if (clr_last) state_next = srdr_pkg::ST_IDLE;
            srdr_pkg::ST_IDLE:  if (sample_acc) state_next = srdr_pkg::ST_RUN;
            srdr_pkg::ST_RUN:   if (run_done) state_next = srdr_pkg::ST_DONE;
            srdr_pkg::ST_DONE:  if (out_load) state_next = srdr_pkg::ST_IDLE;
            default:            state_next = srdr_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = (state_reg == srdr_pkg::ST_IDLE);
        out_load      = (state_reg == srdr_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srdr_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            active_reg  <= srdr_pkg::CFG_W'(32);
            iss_cnt_reg <= '0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == srdr_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
            if (sample_acc) begin
                iss_cnt_reg <= '0;
            end else if (issue) begin
                iss_cnt_reg <= iss_cnt_reg + NW'(1);
            end
            vld_reg <= {vld_reg[6:1], issue};
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic [2*SW-1:0]   dly_mem [DEPTH];
    logic [PW-1:0]     pos_mem [NUM_LINES];
    logic [LENW-1:0]   len_mem [NUM_LINES];
    logic [2*UW-1:0]   gfc_mem [NUM_LINES];    // {filter_coeff, gain_in}
    logic [2*CW_-1:0]  rot_mem [NUM_LINES];    // {im, re}
    logic [2*FW-1:0]   fl_mem  [NUM_LINES];    // {stage2, stage1}
    logic [2*FW-1:0]   fr_mem  [NUM_LINES];

    logic [PW-1:0]     pos_rd;
    logic [LENW-1:0]   len_rd;
    logic [2*UW-1:0]   gfc_rd;
    logic [2*CW_-1:0]  rot_rd;
    logic [2*FW-1:0]   fl_rd, fr_rd;
    logic [2*SW-1:0]   dly_rd;

    logic [LW-1:0]     clr_line;
    logic              clr_line_ok;
    assign clr_line    = clr_cnt_reg[LW-1:0];
    assign clr_line_ok = (state_reg == srdr_pkg::ST_CLEAR) && (32'(clr_line) < NUM_LINES);

    // pipeline stage signals
    logic [LW-1:0]            ln1_reg, ln2_reg, ln3_reg, ln4_reg, ln5_reg;
    logic [PW-1:0]            pos_eff, pos_inc;
    logic [AW-1:0]            a2_reg, a3_reg, a4_reg, a5_reg, a6_reg, a7_reg;

    always_ff @(posedge aclk) begin
        if (clr_line_ok) begin
            len_mem[clr_line] <= LENW'(1);
            gfc_mem[clr_line] <= '0;
            rot_mem[clr_line] <= '0;
        end else if (load_acc) begin
            len_mem[LW'(in_idx)] <= len_clamped;
            gfc_mem[LW'(in_idx)] <= {in_fc, in_gain};
            rot_mem[LW'(in_idx)] <= {in_im, in_re};
        end
        if (clr_line_ok) begin
            pos_mem[clr_line] <= '0;
        end else if (load_acc) begin
            pos_mem[LW'(in_idx)] <= '0;
        end else if (vld_reg[1]) begin
            pos_mem[ln1_reg] <= pos_inc;
        end
        len_rd <= len_mem[iss_cnt_reg[LW-1:0]];
        gfc_rd <= gfc_mem[iss_cnt_reg[LW-1:0]];
        rot_rd <= rot_mem[iss_cnt_reg[LW-1:0]];
        pos_rd <= pos_mem[iss_cnt_reg[LW-1:0]];
    end

    // ------------------------------------------------------------------
    // line pipeline
    // ------------------------------------------------------------------
    logic signed [SW-1:0]  inl_reg, inr_reg;
    logic [UW-1:0]         g2_reg, g3_reg, g4_reg, g5_reg, g6_reg;
    logic [UW-1:0]         fc2_reg, fc3_reg, fc4_reg;
    logic [2*CW_-1:0]      rot2_reg, rot3_reg, rot4_reg, rot5_reg, rot6_reg;
    logic signed [FW-1:0]  s0l2_reg, s1l2_reg, s0r2_reg, s1r2_reg;
    logic signed [FW-1:0]  s0l3_reg, s1l3_reg, s0r3_reg, s1r3_reg;
    logic signed [FW-1:0]  s0l4_reg, s1l4_reg, s0r4_reg, s1r4_reg;
    logic signed [FW-1:0]  s0l5_reg, s0r5_reg, s1l5_reg, s1r5_reg;
    logic signed [FW-1:0]  yl6_reg, yr6_reg;
    logic signed [PRW-1:0] pl3_reg, pr3_reg, pl5_reg, pr5_reg;
    logic signed [DW-1:0]  xl, xr;
    logic signed [PRW-1:0] fc_s;
    logic signed [PRW-1:0] rl3, rr3, rl5, rr5;
    logic signed [FW-1:0]  s0l_new, s0r_new, yl_new, yr_new;
    logic signed [RW-1:0]  re_yl7_reg, im_yr7_reg, re_yr7_reg, im_yl7_reg;
    logic signed [GW-1:0]  gl7_reg, gr7_reg;
    logic signed [CW_-1:0] re6, im6;
    logic signed [CW_-1:0] g6_s;
    logic signed [TW-1:0]  tl, tr;
    logic signed [TW-CF-G-1:0] ql, qr;
    logic signed [SW-1:0]  wl, wr;
    logic signed [ACCW-1:0] accl_reg, accr_reg;

    assign pos_eff = (LENW'(pos_rd) >= len_rd) ? '0 : pos_rd;
    assign pos_inc = (LENW'(pos_eff) + LENW'(1) >= len_rd) ? '0 : pos_eff + PW'(1);

    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            inl_reg <= $signed(in_sl);
            inr_reg <= $signed(in_sr);
        end
        // stage 1 -> 2: line settings and filter state
        ln1_reg  <= iss_cnt_reg[LW-1:0];
        ln2_reg  <= ln1_reg;
        a2_reg   <= {ln1_reg, pos_eff};
        g2_reg   <= gfc_rd[UW-1:0];
        fc2_reg  <= gfc_rd[2*UW-1:UW];
        rot2_reg <= rot_rd;
        s0l2_reg <= $signed(fl_rd[FW-1:0]);
        s1l2_reg <= $signed(fl_rd[2*FW-1:FW]);
        s0r2_reg <= $signed(fr_rd[FW-1:0]);
        s1r2_reg <= $signed(fr_rd[2*FW-1:FW]);
    end

    always_ff @(posedge aclk) begin
        if (vld_reg[5]) begin
            fl_mem[ln5_reg] <= {yl_new, s0l5_reg};
            fr_mem[ln5_reg] <= {yr_new, s0r5_reg};
        end else if (clr_line_ok) begin
            fl_mem[clr_line] <= '0;
            fr_mem[clr_line] <= '0;
        end
        fl_rd <= fl_mem[iss_cnt_reg[LW-1:0]];
        fr_rd <= fr_mem[iss_cnt_reg[LW-1:0]];
    end

    // first lowpass stage
    assign xl   = DW'($signed(dly_rd[SW-1:0])) <<< G;
    assign xr   = DW'($signed(dly_rd[2*SW-1:SW])) <<< G;
    assign fc_s = PRW'($signed({1'b0, fc2_reg}));

    assign rl3     = pl3_reg + PRW'(2 ** (CF - 1));
    assign rr3     = pr3_reg + PRW'(2 ** (CF - 1));
    assign s0l_new = s0l3_reg + rl3[CF +: FW];
    assign s0r_new = s0r3_reg + rr3[CF +: FW];
    assign rl5     = pl5_reg + PRW'(2 ** (CF - 1));
    assign rr5     = pr5_reg + PRW'(2 ** (CF - 1));
    assign yl_new  = s1l5_reg + rl5[CF +: FW];
    assign yr_new  = s1r5_reg + rr5[CF +: FW];

    always_ff @(posedge aclk) begin
        // stage 2 -> 3
        pl3_reg  <= PRW'(xl - DW'(s0l2_reg)) * fc_s;
        pr3_reg  <= PRW'(xr - DW'(s0r2_reg)) * fc_s;
        s0l3_reg <= s0l2_reg;
        s1l3_reg <= s1l2_reg;
        s0r3_reg <= s0r2_reg;
        s1r3_reg <= s1r2_reg;
        ln3_reg  <= ln2_reg;
        a3_reg   <= a2_reg;
        g3_reg   <= g2_reg;
        fc3_reg  <= fc2_reg;
        rot3_reg <= rot2_reg;
        // stage 3 -> 4
        s0l4_reg <= s0l_new;
        s0r4_reg <= s0r_new;
        s1l4_reg <= s1l3_reg;
        s1r4_reg <= s1r3_reg;
        ln4_reg  <= ln3_reg;
        a4_reg   <= a3_reg;
        g4_reg   <= g3_reg;
        fc4_reg  <= fc3_reg;
        rot4_reg <= rot3_reg;
        // stage 4 -> 5: second lowpass stage product
        pl5_reg  <= PRW'(DW'(s0l4_reg) - DW'(s1l4_reg)) * PRW'($signed({1'b0, fc4_reg}));
        pr5_reg  <= PRW'(DW'(s0r4_reg) - DW'(s1r4_reg)) * PRW'($signed({1'b0, fc4_reg}));
        s0l5_reg <= s0l4_reg;
        s0r5_reg <= s0r4_reg;
        s1l5_reg <= s1l4_reg;
        s1r5_reg <= s1r4_reg;
        ln5_reg  <= ln4_reg;
        a5_reg   <= a4_reg;
        g5_reg   <= g4_reg;
        rot5_reg <= rot4_reg;
        // stage 5 -> 6
        yl6_reg  <= yl_new;
        yr6_reg  <= yr_new;
        a6_reg   <= a5_reg;
        g6_reg   <= g5_reg;
        rot6_reg <= rot5_reg;
    end

    assign re6  = $signed(rot6_reg[CW_-1:0]);
    assign im6  = $signed(rot6_reg[2*CW_-1:CW_]);
    assign g6_s = $signed({1'b0, g6_reg});

    // stage 6 -> 7: rotation and input gain products
    always_ff @(posedge aclk) begin
        re_yl7_reg <= RW'(re6) * RW'(yl6_reg);
        im_yr7_reg <= RW'(im6) * RW'(yr6_reg);
        re_yr7_reg <= RW'(re6) * RW'(yr6_reg);
        im_yl7_reg <= RW'(im6) * RW'(yl6_reg);
        gl7_reg    <= (GW'(g6_s) * GW'(inl_reg)) <<< G;
        gr7_reg    <= (GW'(g6_s) * GW'(inr_reg)) <<< G;
        a7_reg     <= a6_reg;
    end

    // stage 7: round, saturate, write back
    assign tl = TW'(re_yl7_reg) - TW'(im_yr7_reg) + TW'(gl7_reg) + TW'(2 ** (CF + G - 1));
    assign tr = TW'(re_yr7_reg) + TW'(im_yl7_reg) + TW'(gr7_reg) + TW'(2 ** (CF + G - 1));
    assign ql = tl[TW-1:CF+G];
    assign qr = tr[TW-1:CF+G];

    always_comb begin
        if (ql > (TW-CF-G)'(srdr_pkg::SMAX)) begin
            wl = srdr_pkg::SMAX;
        end else if (ql < (TW-CF-G)'(srdr_pkg::SMIN)) begin
            wl = srdr_pkg::SMIN;
        end else begin
            wl = SW'(ql);
        end
        if (qr > (TW-CF-G)'(srdr_pkg::SMAX)) begin
            wr = srdr_pkg::SMAX;
        end else if (qr < (TW-CF-G)'(srdr_pkg::SMIN)) begin
            wr = srdr_pkg::SMIN;
        end else begin
            wr = SW'(qr);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == srdr_pkg::ST_CLEAR) begin
            dly_mem[clr_cnt_reg] <= '0;
        end else if (vld_reg[7]) begin
            dly_mem[a7_reg] <= {wr, wl};
        end
        dly_rd <= dly_mem[{ln1_reg, pos_eff}];
    end

    // ------------------------------------------------------------------
    // accumulate filtered outputs and mix
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (sample_acc) begin
            accl_reg <= '0;
            accr_reg <= '0;
        end else if (vld_reg[6]) begin
            accl_reg <= accl_reg + ACCW'(yl6_reg);
            accr_reg <= accr_reg + ACCW'(yr6_reg);
        end
    end

    localparam int MXW = ACCW - G;
    logic signed [ACCW-1:0] hl, hr;
    logic signed [MXW-1:0]  ml, mr;
    logic signed [SW-1:0]   ol, orr;
    logic [2*SW-1:0]        out_reg;

    assign hl = accl_reg + ACCW'(2 ** G);
    assign hr = accr_reg + ACCW'(2 ** G);
    assign ml = MXW'($signed(hl[ACCW-1:G+1])) + MXW'(inl_reg);
    assign mr = MXW'($signed(hr[ACCW-1:G+1])) + MXW'(inr_reg);

    always_comb begin
        if (ml > MXW'(srdr_pkg::SMAX)) begin
            ol = srdr_pkg::SMAX;
        end else if (ml < MXW'(srdr_pkg::SMIN)) begin
            ol = srdr_pkg::SMIN;
        end else begin
            ol = SW'(ml);
        end
        if (mr > MXW'(srdr_pkg::SMAX)) begin
            orr = srdr_pkg::SMAX;
        end else if (mr < MXW'(srdr_pkg::SMIN)) begin
            orr = srdr_pkg::SMIN;
        end else begin
            orr = SW'(mr);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= {orr, ol};
        end
    end

    assign m_axis_tdata = out_reg;

`ifndef SYNTHESIS
    // line work only happens while a sample item runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg != '0) |-> (state_reg == srdr_pkg::ST_RUN))
        else $error("line pipeline active outside a sample run");

    // no item is taken while lines are in flight or the memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> ((vld_reg == '0) && !issue))
        else $error("input ready while the pipeline is busy");

    // a result is loaded only once the pipeline has fully drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (vld_reg == '0) && (state_reg == srdr_pkg::ST_DONE))
        else $error("result loaded before all lines finished");
`endif

endmodule

`default_nettype wire

@@ verif/stereo_rotating_delay_reverb_test.sv @@
// ----------------------------------------------------------------------------
// stereo_rotating_delay_reverb_test: self-checking bench of the stereo reverb
// Loads delay lines and streams stereo samples through them. A bit-exact
// reverb predictor computes each output pair, and results are compared in
// order. Runs through several active-line settings, idling and receiver-stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stereo_rotating_delay_reverb_test;

    localparam int NLINES = 32;
    localparam int MAXD   = 8192;

    localparam int CFG_W    = srdr_pkg::CFG_W;
    localparam int S_DATA_W = srdr_pkg::S_DATA_W;
    localparam int M_DATA_W = srdr_pkg::M_DATA_W;
    localparam int IDX_W    = srdr_pkg::IDX_W;
    localparam int LEN_FW   = srdr_pkg::LEN_FW;
    localparam int UCOEF_W  = srdr_pkg::UCOEF_W;
    localparam int COEF_W   = srdr_pkg::COEF_W;
    localparam int SAMPLE_W = srdr_pkg::SAMPLE_W;
    localparam int CFRAC    = srdr_pkg::CFRAC;
    localparam int GUARD    = srdr_pkg::GUARD;
    localparam int OFS_IDX  = srdr_pkg::OFS_IDX;
    localparam int OFS_LEN  = srdr_pkg::OFS_LEN;
    localparam int OFS_GAIN = srdr_pkg::OFS_GAIN;
    localparam int OFS_RE   = srdr_pkg::OFS_RE;
    localparam int OFS_IM   = srdr_pkg::OFS_IM;
    localparam int OFS_FC   = srdr_pkg::OFS_FC;
    localparam int OFS_SL   = srdr_pkg::OFS_SL;
    localparam int OFS_SR   = srdr_pkg::OFS_SR;
    localparam logic ACT_SAMPLE = srdr_pkg::ACT_SAMPLE;
    localparam logic ACT_LOAD   = srdr_pkg::ACT_LOAD;
    localparam logic signed [SAMPLE_W-1:0] SMAX = srdr_pkg::SMAX;
    localparam logic signed [SAMPLE_W-1:0] SMIN = srdr_pkg::SMIN;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_W-1:0]          cfg_wr_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [S_DATA_W-1:0]       s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [M_DATA_W-1:0]       m_axis_tdata;

    stereo_rotating_delay_reverb u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct {
        logic                        action;
        logic [IDX_W-1:0]            idx;
        logic [LEN_FW-1:0]           len;
        logic [UCOEF_W-1:0]          gain;
        logic signed [COEF_W-1:0]    re;
        logic signed [COEF_W-1:0]    im;
        logic [UCOEF_W-1:0]          fc;
        logic signed [SAMPLE_W-1:0]  sl;
        logic signed [SAMPLE_W-1:0]  sr;
        bit                          typed;  // expected pair typed in below
        logic signed [SAMPLE_W-1:0]  el;
        logic signed [SAMPLE_W-1:0]  er;
    } reverb_item_t;

    // reverb state kept by the predictor
    logic signed [SAMPLE_W-1:0] echo_l [NLINES*MAXD];
    logic signed [SAMPLE_W-1:0] echo_r [NLINES*MAXD];
    int unsigned  tap_pos  [NLINES];
    int unsigned  tap_len  [NLINES];
    longint       tap_gain [NLINES];
    longint       tap_fc   [NLINES];
    longint       tap_re   [NLINES];
    longint       tap_im   [NLINES];
    longint       lp_l     [NLINES][2];
    longint       lp_r     [NLINES][2];
    int unsigned  lines_on;

    logic [M_DATA_W-1:0] pending_mix [$];
    int  errors;
    bit  drain_done;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("stereo_rotating_delay_reverb: mismatch");
        $finish;
    end

    function automatic longint rnd_half_up(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip24(longint v);
        if (v > longint'(SMAX)) return longint'(SMAX);
        if (v < longint'(SMIN)) return longint'(SMIN);
        return v;
    endfunction

    function automatic longint smooth(inout longint st[2], input longint x, input longint fc);
        st[0] += rnd_half_up(fc * (x - st[0]), CFRAC);
        st[1] += rnd_half_up(fc * (st[0] - st[1]), CFRAC);
        return st[1];
    endfunction

    task automatic reset_reverb();
        for (int i = 0; i < NLINES*MAXD; i++) begin
            echo_l[i] = '0;
            echo_r[i] = '0;
        end
        for (int i = 0; i < NLINES; i++) begin
            tap_pos[i] = 0; tap_len[i] = 1;
            tap_gain[i] = 0; tap_fc[i] = 0; tap_re[i] = 0; tap_im[i] = 0;
            lp_l[i] = '{0, 0}; lp_r[i] = '{0, 0};
        end
        lines_on = 32;
    endtask

    task automatic predict_reverb(input reverb_item_t it);
        longint in_l, in_r, sum_l, sum_r, yl, yr, wl, wr, ol, or_;
        int unsigned n, len, a;
        if (it.action == ACT_LOAD) begin
            len = 32'(it.len);
            if (len < 1) len = 1;
            if (len > MAXD) len = MAXD;
            tap_len[it.idx]  = len;
            tap_gain[it.idx] = longint'(it.gain);
            tap_fc[it.idx]   = longint'(it.fc);
            tap_re[it.idx]   = longint'(it.re);
            tap_im[it.idx]   = longint'(it.im);
            tap_pos[it.idx]  = 0;
            return;
        end
        in_l = longint'(it.sl);
        in_r = longint'(it.sr);
        sum_l = 0;
        sum_r = 0;
        n = (lines_on > NLINES) ? NLINES : lines_on;
        for (int i = 0; i < n; i++) begin
            a  = i * MAXD + tap_pos[i];
            yl = smooth(lp_l[i], longint'(echo_l[a]) * 256, tap_fc[i]);
            yr = smooth(lp_r[i], longint'(echo_r[a]) * 256, tap_fc[i]);
            wl = clip24(rnd_half_up(tap_re[i]*yl - tap_im[i]*yr + tap_gain[i]*in_l*256,
                                    CFRAC + GUARD));
            wr = clip24(rnd_half_up(tap_re[i]*yr + tap_im[i]*yl + tap_gain[i]*in_r*256,
                                    CFRAC + GUARD));
            echo_l[a] = wl[SAMPLE_W-1:0];
            echo_r[a] = wr[SAMPLE_W-1:0];
            tap_pos[i] = (tap_pos[i] + 1 >= tap_len[i]) ? 0 : tap_pos[i] + 1;
            sum_l += yl;
            sum_r += yr;
        end
        ol  = clip24(in_l + rnd_half_up(sum_l, GUARD + 1));
        or_ = clip24(in_r + rnd_half_up(sum_r, GUARD + 1));
        pending_mix.push_back({or_[SAMPLE_W-1:0], ol[SAMPLE_W-1:0]});
    endtask

    task automatic send_item(input reverb_item_t it);
        logic [M_DATA_W-1:0] predicted;
        logic [S_DATA_W-1:0] packed_data;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        predict_reverb(it);
        if (it.typed && it.action == ACT_SAMPLE) begin
            predicted = pending_mix[$];
            if (predicted !== {it.er, it.el}) begin
                $display("%0t: table row disagrees expected %h actual %h", $time,
                         {it.er, it.el}, predicted);
                errors++;
            end
        end
        packed_data = '0;
        packed_data[OFS_IDX +: IDX_W]     = it.idx;
        packed_data[OFS_LEN +: LEN_FW]    = it.len;
        packed_data[OFS_GAIN +: UCOEF_W]  = it.gain;
        packed_data[OFS_RE +: COEF_W]     = it.re;
        packed_data[OFS_IM +: COEF_W]     = it.im;
        packed_data[OFS_FC +: UCOEF_W]    = it.fc;
        packed_data[OFS_SL +: SAMPLE_W]   = it.sl;
        packed_data[OFS_SR +: SAMPLE_W]   = it.sr;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= packed_data;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // wait for every result, then let the pipeline settle before a write
    task automatic write_lines_on(input logic [CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        lines_on = 32'(v);
    endtask

    function automatic reverb_item_t load_item(int idx, int len, int g, int re, int im, int fc);
        reverb_item_t it;
        it = '{default: '0};
        it.action = ACT_LOAD;
        it.idx = IDX_W'(idx); it.len = LEN_FW'(len); it.gain = UCOEF_W'(g);
        it.re = COEF_W'(re); it.im = COEF_W'(im); it.fc = UCOEF_W'(fc);
        it.sl = SAMPLE_W'($urandom); it.sr = SAMPLE_W'($urandom);
        return it;
    endfunction

    function automatic reverb_item_t sample_item(int l, int r);
        reverb_item_t it;
        it = '{default: '0};
        it.action = ACT_SAMPLE;
        it.sl = SAMPLE_W'(l); it.sr = SAMPLE_W'(r);
        it.idx = IDX_W'($urandom); it.len = LEN_FW'($urandom);
        it.gain = UCOEF_W'($urandom);
        it.re = COEF_W'($urandom); it.im = COEF_W'($urandom);
        it.fc = UCOEF_W'($urandom);
        return it;
    endfunction

    function automatic reverb_item_t typed_sample(int l, int r, int el, int er);
        reverb_item_t it;
        it = sample_item(l, r);
        it.typed = 1'b1;
        it.el = SAMPLE_W'(el); it.er = SAMPLE_W'(er);
        return it;
    endfunction

    function automatic reverb_item_t random_item(int max_len);
        reverb_item_t it;
        if ($urandom_range(99) < 15)
            it = load_item($urandom, $urandom_range(max_len), $urandom, $urandom, $urandom,
                           $urandom);
        else
            it = sample_item($urandom, $urandom);
        if ($urandom_range(9) == 0) it.sl = $urandom_range(1) ? SMAX : SMIN;
        if ($urandom_range(9) == 0) it.sr = $urandom_range(1) ? SMAX : SMIN;
        return it;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_mix.size() == 0) begin
                $display("%0t: unexpected output expected none actual %h", $time,
                         m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata[SAMPLE_W-1:0] !== pending_mix[0][SAMPLE_W-1:0]) begin
                    $display("%0t: out_left expected %h actual %h", $time,
                             pending_mix[0][SAMPLE_W-1:0], m_axis_tdata[SAMPLE_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[M_DATA_W-1:SAMPLE_W] !== pending_mix[0][M_DATA_W-1:SAMPLE_W])
                begin
                    $display("%0t: out_right expected %h actual %h", $time,
                             pending_mix[0][M_DATA_W-1:SAMPLE_W],
                             m_axis_tdata[M_DATA_W-1:SAMPLE_W]);
                    errors++;
                end
                void'(pending_mix.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!drain_done && recv_stall_pct > 0)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        else
            m_axis_tready <= 1'b1;
    end

    initial begin
        reverb_item_t directed [$];
        int phase_idle [4]  = '{0, 64, 0, 34};
        int phase_stall [4] = '{0, 0, 64, 34};
        logic [CFG_W-1:0] phase_lines [4] = '{6'd1, 6'd63, 6'd0, 6'd7};
        int wait_cnt;

        errors = 0;
        drain_done = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_SAMPLE;
        m_axis_tready = 1'b1;
        reset_reverb();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // after reset every line has zero gain: output equals input
        directed.push_back(typed_sample(0, 0, 0, 0));
        directed.push_back(typed_sample(SMAX, SMIN, SMAX, SMIN));
        directed.push_back(typed_sample(SMIN, SMAX, SMIN, SMAX));
        directed.push_back(load_item(0, 0, 131071, 131071, -131072, 131071));        // zero length
        directed.push_back(load_item(1, 16383, 131071, -131072, 131071, 0));         // over max
        directed.push_back(load_item(2, 8192, 65536, 65536, 0, 65536));
        directed.push_back(load_item(3, 1, 131071, 0, 131071, 131071));
        directed.push_back(load_item(31, 3, 100000, -100000, -100000, 40000));
        for (int i = 0; i < 6; i++)
            directed.push_back(sample_item(i[0] ? SMAX : SMIN, i[1] ? SMIN : SMAX));
        directed.push_back(load_item(0, 2, 0, 131071, 131071, 131071));               // reload
        directed.push_back(sample_item(12345, -54321));
        directed.push_back(sample_item(SMAX, SMAX));
        directed.push_back(sample_item(SMIN, SMIN));
        foreach (directed[k]) send_item(directed[k]);

        // also catches the exactly-zero active lines case in phase 2
        for (int p = 0; p < 4; p++) begin
            write_lines_on(phase_lines[p]);
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int k = 0; k < 30; k++) send_item(random_item(16));
            write_lines_on(CFG_W'($urandom_range(1, 32)));
            for (int k = 0; k < 90; k++) send_item(random_item(k < 85 ? 40 : 16383));
        end
        write_lines_on(6'd32);
        for (int k = 0; k < 20; k++) send_item(random_item(8));
        s_axis_tvalid <= 1'b0;

        drain_done = 1'b1;
        wait_cnt = 0;
        while (pending_mix.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_mix.size() == 0) begin
            $display("stereo_rotating_delay_reverb: match");
        end else begin
            $display("stereo_rotating_delay_reverb: mismatch");
        end
        $finish;
    end

endmodule
